/* sv/zfbm_pkg.sv */
// zfbm_pkg: shared types, constants and zone tables for the zoned floppy block mapper
// no dependencies; used by the interfaces, zfbm_div and zoned_floppy_block_mapper
package zfbm_pkg;

    // field widths
    localparam int BLOCK_W  = 12;
    localparam int TRACK_W  = 7;
    localparam int SECTOR_W = 4;
    localparam int PART_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int OFF_W    = 9;    // zone-relative block offset, below 384
    localparam int QUOT_W   = 5;    // zone-relative track count, below 32
    localparam int RECIP_W  = 14;
    localparam int RECIP_SH = 16;

    // geometry
    localparam logic [BLOCK_W-1:0] DISK_ONE_SIDE = 12'd800;
    localparam logic [BLOCK_W-1:0] DISK_TWO_SIDE = 12'd1600;
    localparam logic [PART_W-1:0]  PART_RESET    = 10'd800;
    localparam int ZONE_COUNT = 5;

    typedef logic [2:0] t_zone;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_AT_END    = 2'd1,
        ST_BEYOND    = 2'd2,
        ST_PROTECTED = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_SIDED       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_PROTECTED = 2'd2;

    // first block of each zone on one side
    function automatic logic [PART_W-1:0] zone_start(t_zone z);
        logic [PART_W-1:0] s;
        unique case (z)
            3'd0:    s = 10'd0;
            3'd1:    s = 10'd192;
            3'd2:    s = 10'd368;
            3'd3:    s = 10'd528;
            3'd4:    s = 10'd672;
            default: s = 10'd0;
        endcase
        return s;
    endfunction

    // sectors per track in each zone
    function automatic logic [SECTOR_W-1:0] zone_sectors(t_zone z);
        logic [SECTOR_W-1:0] d;
        unique case (z)
            3'd0:    d = 4'd12;
            3'd1:    d = 4'd11;
            3'd2:    d = 4'd10;
            3'd3:    d = 4'd9;
            3'd4:    d = 4'd8;
            default: d = 4'd8;
        endcase
        return d;
    endfunction

    // ceil(2^16 / sectors), exact for offsets far beyond 384
    function automatic logic [RECIP_W-1:0] zone_recip(t_zone z);
        logic [RECIP_W-1:0] m;
        unique case (z)
            3'd0:    m = 14'd5462;
            3'd1:    m = 14'd5958;
            3'd2:    m = 14'd6554;
            3'd3:    m = 14'd7282;
            3'd4:    m = 14'd8192;
            default: m = 14'd8192;
        endcase
        return m;
    endfunction

endpackage

/* sv/zfbm_if.sv */
// zfbm_if: valid/ready channel interfaces for requests, results and configuration writes
// depends on zfbm_pkg for field widths
interface zfbm_req_if;
    logic                          valid;
    logic                          ready;
    logic [zfbm_pkg::BLOCK_W-1:0]  block_number;
    logic                          is_write;

    modport source (output valid, block_number, is_write, input ready);
    modport sink   (input valid, block_number, is_write, output ready);
endinterface

interface zfbm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [zfbm_pkg::TRACK_W-1:0]  track;
    logic                          head_side;
    logic [zfbm_pkg::SECTOR_W-1:0] sector;
    logic [1:0]                    status;

    modport source (output valid, track, head_side, sector, status, input ready);
    modport sink   (input valid, track, head_side, sector, status, output ready);
endinterface

interface zfbm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [zfbm_pkg::CFG_IDX_W-1:0]  index;
    logic [zfbm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/zfbm_div.sv */
// zfbm_div: division of a zone-relative offset by the zone's sectors per track
// reciprocal multiply into a register, remainder from the registered quotient; uses zfbm_pkg
module zfbm_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [zfbm_pkg::OFF_W-1:0]     i_off,
    input  zfbm_pkg::t_zone                i_zone,
    output logic [zfbm_pkg::QUOT_W-1:0]    o_quot,
    output logic [zfbm_pkg::SECTOR_W-1:0]  o_rem
);
    import zfbm_pkg::*;

    logic [OFF_W+RECIP_W-1:0] w_prod;
    logic [QUOT_W-1:0]        n_quot;
    logic [QUOT_W-1:0]        r_quot;
    logic [OFF_W-1:0]         r_off;
    logic [SECTOR_W-1:0]      r_div;
    logic [OFF_W-1:0]         w_back;

    // quotient by reciprocal multiply
    always_comb begin
        w_prod = (OFF_W+RECIP_W)'(i_off) * (OFF_W+RECIP_W)'(zone_recip(i_zone));
        n_quot = w_prod[RECIP_SH +: QUOT_W];
    end

    // quotient stage register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot <= n_quot;
            r_off  <= i_off;
            r_div  <= zone_sectors(i_zone);
        end
    end

    // remainder from quotient times divisor
    always_comb begin
        w_back = OFF_W'(r_quot) * OFF_W'(r_div);
    end

    assign o_quot = r_quot;
    assign o_rem  = SECTOR_W'(r_off - w_back);

endmodule

/* sv/zoned_floppy_block_mapper.sv */
// zoned_floppy_block_mapper: top level of the zoned floppy block mapper
// depends on zfbm_pkg, the zfbm_*_if interfaces and zfbm_div
//
// Usage:
//   i_req carries a logical block number and a write flag; o_rsp returns the
//   track, head, sector and a status code (ok, at end of partition, beyond
//   end, write protected). Every request yields exactly one result, in order.
//   i_cfg writes the two-sided flag, the partition size and the write-protect
//   flag by register index; it is always ready, and writes to an unused index
//   are dropped. Write configuration only while no request is in flight.
// Timing:
//   three register stages (limit check and zone select, reciprocal multiply,
//   remainder and track assembly); a result is valid once its request has
//   passed all three registers. One request per cycle is accepted while
//   o_rsp.ready stays high.
// Reset and stalls:
//   reset empties the pipeline and loads one-sided, 800 blocks, unprotected.
//   When o_rsp.ready is low the output register holds its result and the
//   earlier stages keep filling until every stage is full; then i_req.ready
//   drops, and nothing is lost or repeated.
module zoned_floppy_block_mapper (
    input  logic i_clk,
    input  logic i_rst_n,
    zfbm_req_if.sink   i_req,
    zfbm_cfg_if.sink   i_cfg,
    zfbm_rsp_if.source o_rsp
);
    import zfbm_pkg::*;

    // configuration registers
    logic              r_two_sided;
    logic [PART_W-1:0] r_part;
    logic              r_wprot;

    // pipeline valid bits and stage advance
    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;

    // stage 1 payload
    t_status         r_st1;
    t_zone           r_z1;
    logic [OFF_W-1:0] r_off1;

    // stage 2 payload
    t_status r_st2;
    t_zone   r_z2;

    // stage 3 (output) payload
    logic [TRACK_W-1:0]  r_track;
    logic                r_head;
    logic [SECTOR_W-1:0] r_sector;
    t_status             r_st3;

    // stage 1 combinational
    logic [BLOCK_W-1:0] w_limit;
    logic [BLOCK_W-1:0] w_disk;
    logic [BLOCK_W-1:0] w_bound;
    logic [BLOCK_W-1:0] w_start;
    logic [BLOCK_W-1:0] w_rel;
    t_status            n_st1;
    t_zone              n_z1;

    // stage 3 combinational
    logic [QUOT_W-1:0]   w_quot;
    logic [SECTOR_W-1:0] w_rem;
    logic [TRACK_W-1:0]  n_track;
    logic                n_head;
    logic [SECTOR_W-1:0] n_sector;

    // ready chain, output register first
    assign w_adv3 = !r_v3 || o_rsp.ready;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;
    assign i_req.ready = w_adv1;
    assign i_cfg.ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_sided <= 1'b0;
            r_part      <= PART_RESET;
            r_wprot     <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TWO_SIDED:       r_two_sided <= i_cfg.data[0];
                CFG_PARTITION:       r_part      <= i_cfg.data[PART_W-1:0];
                CFG_WRITE_PROTECTED: r_wprot     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // limit checks, zone select and zone-relative offset
    always_comb begin
        w_limit = r_two_sided ? {1'b0, r_part, 1'b0} : {2'b00, r_part};
        w_disk  = r_two_sided ? DISK_TWO_SIDE : DISK_ONE_SIDE;

        if (i_req.block_number == w_limit) begin
            n_st1 = ST_AT_END;
        end else if (i_req.block_number > w_limit) begin
            n_st1 = ST_BEYOND;
        end else if (i_req.is_write && r_wprot) begin
            n_st1 = ST_PROTECTED;
        end else if (i_req.block_number >= w_disk) begin
            n_st1 = ST_BEYOND;
        end else begin
            n_st1 = ST_OK;
        end

        n_z1 = '0;
        for (int k = 1; k < ZONE_COUNT; k++) begin
            w_bound = BLOCK_W'(zone_start(t_zone'(k))) << r_two_sided;
            if (i_req.block_number >= w_bound) begin
                n_z1 = t_zone'(k);
            end
        end

        w_start = BLOCK_W'(zone_start(n_z1)) << r_two_sided;
        w_rel   = i_req.block_number - w_start;
    end

    // stage 1 register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv1) begin
            r_v1 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_st1  <= n_st1;
            r_z1   <= n_z1;
            r_off1 <= w_rel[OFF_W-1:0];
        end
    end

    // stage 2: divider holds quotient, sideband moves alongside
    zfbm_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_adv2),
        .i_off  (r_off1),
        .i_zone (r_z1),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_st2 <= r_st1;
            r_z2  <= r_z1;
        end
    end

    // track and head assembly; non-ok results carry zero fields
    always_comb begin
        if (r_st2 != ST_OK) begin
            n_track  = '0;
            n_head   = 1'b0;
            n_sector = '0;
        end else if (r_two_sided) begin
            n_track  = {r_z2, 4'b0000} + TRACK_W'(w_quot[QUOT_W-1:1]);
            n_head   = w_quot[0];
            n_sector = w_rem;
        end else begin
            n_track  = {r_z2, 4'b0000} + TRACK_W'(w_quot);
            n_head   = 1'b0;
            n_sector = w_rem;
        end
    end

    // stage 3 output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_track  <= n_track;
            r_head   <= n_head;
            r_sector <= n_sector;
            r_st3    <= r_st2;
        end
    end

    assign o_rsp.valid     = r_v3;
    assign o_rsp.track     = r_track;
    assign o_rsp.head_side = r_head;
    assign o_rsp.sector    = r_sector;
    assign o_rsp.status    = r_st3;

`ifndef SYNTHESIS
    // a refused or out-of-range request never carries a location
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |->
            (o_rsp.track == '0 && o_rsp.sector == '0 && !o_rsp.head_side))
        else $error("non-ok result carries a location");

    // a mapped block lands on the disk
    a_geom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_OK) |->
            (o_rsp.track < 7'd80 && o_rsp.sector < 4'd12))
        else $error("mapped location off the disk");

    // one-sided disks use head zero only
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !r_two_sided) |-> !o_rsp.head_side)
        else $error("head one on a one-sided disk");

    // an empty output register never blocks the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v3 |-> i_req.ready)
        else $error("input stalled with empty output");

    // a stalled result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !o_rsp.ready) |=> (r_v3 && $stable(r_track) && $stable(r_sector)
            && $stable(r_st3) && $stable(r_head)))
        else $error("stalled result changed");
`endif

endmodule
